// ===== rtl/cfhd_pkg.sv =====
// Shared types and constants for the camera frame header deframer.
// No dependencies; the RTL modules and the testbench import this package.
`default_nettype none

package cfhd_pkg;

    localparam int HEADER_BYTES = 16;
    localparam int SIDE_W       = 13;
    localparam int TOTAL_W      = 2 * SIDE_W;
    localparam int PIXCNT_W     = 24;
    localparam int FRAMECNT_W   = 32;
    localparam int CFG_IDX_W    = 1;

    localparam logic [7:0] SYNC_A = 8'h33;
    localparam logic [7:0] SYNC_B = 8'hCC;
    localparam logic [7:0] SYNC_C = 8'h22;
    localparam logic [7:0] SYNC_D = 8'hDD;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [SIDE_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [SIDE_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic                  valid;
        logic [7:0]            pixel;
        logic                  frame_last;
        logic [FRAMECNT_W-1:0] frame_number;
    } cfhd_result_t;

endpackage

`default_nettype wire

// ===== rtl/cfhd_byte_if.sv =====
// Raw byte stream channel: valid/ready handshake with one byte of payload.
// Depends on nothing.
`default_nettype none

interface cfhd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/cfhd_pixel_if.sv =====
// Pixel stream channel: valid/ready handshake carrying pixel, last flag and frame number.
// Depends on nothing.
`default_nettype none

interface cfhd_pixel_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel;
    logic        frame_last;
    logic [31:0] frame_number;

    modport source (output valid, output pixel, output frame_last, output frame_number,
                    input ready);
    modport sink (input valid, input pixel, input frame_last, input frame_number,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/cfhd_window.sv =====
// Sliding 16-byte header window with sync pattern detection.
// Depends on cfhd_pkg.
`default_nettype none

module cfhd_window
    import cfhd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift,
    input  wire logic [7:0] in_byte,
    output logic            header_hit
);

    logic [7:0] window_reg  [HEADER_BYTES];
    logic [7:0] window_next [HEADER_BYTES];

    always_comb
    begin
        for (int i = 0; i < HEADER_BYTES - 1; i++)
        begin
            window_next[i] = window_reg[i+1];
        end
        window_next[HEADER_BYTES-1] = in_byte;
    end

    assign header_hit = shift
                        && (window_next[0] == SYNC_A)
                        && (window_next[1] == SYNC_B)
                        && (window_next[HEADER_BYTES-2] == SYNC_C)
                        && (window_next[HEADER_BYTES-1] == SYNC_D);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (header_hit)
        begin
            // clear so the next header needs a full window of new bytes
            for (int i = 0; i < HEADER_BYTES; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            window_reg <= window_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cfhd_payload.sv =====
// Payload tracking: pixel index, end-of-frame detection and frame counter.
// Depends on cfhd_pkg.
`default_nettype none

module cfhd_payload
    import cfhd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        in_byte,
    input  wire logic              header_hit,
    input  wire logic [SIDE_W-1:0] width,
    input  wire logic [SIDE_W-1:0] height,
    output logic                   in_payload,
    output cfhd_result_t           result
);

    logic                  in_payload_reg;
    logic [PIXCNT_W-1:0]   pixel_cnt_reg;
    logic [FRAMECNT_W-1:0] frame_cnt_reg;
    logic [TOTAL_W-1:0]    total;
    logic [PIXCNT_W:0]     pixel_cnt_inc;
    logic                  last;

    assign total         = width * height;
    assign pixel_cnt_inc = {1'b0, pixel_cnt_reg} + {{PIXCNT_W{1'b0}}, 1'b1};
    assign last          = {{(TOTAL_W-PIXCNT_W-1){1'b0}}, pixel_cnt_inc} >= total;
    assign in_payload    = in_payload_reg;

    assign result.valid        = accept && in_payload_reg;
    assign result.pixel        = in_byte;
    assign result.frame_last   = last;
    assign result.frame_number = frame_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg <= 1'b0;
            pixel_cnt_reg  <= '0;
            frame_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            if (in_payload_reg)
            begin
                if (last)
                begin
                    in_payload_reg <= 1'b0;
                    pixel_cnt_reg  <= '0;
                end
                else
                begin
                    pixel_cnt_reg <= pixel_cnt_inc[PIXCNT_W-1:0];
                end
            end
            else if (header_hit)
            begin
                in_payload_reg <= 1'b1;
                pixel_cnt_reg  <= '0;
                frame_cnt_reg  <= frame_cnt_reg + 32'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/camera_frame_header_deframer.sv =====
// Camera frame header deframer: takes one raw byte per transfer and, after a 16-byte
// header (0x33 0xCC at its start, 0x22 0xDD at its end), passes frame_width*frame_height
// bytes out as pixels, tagged with the frame count and flagged last on the final one.
// A byte is taken every clock while the output register is empty or being drained;
// each pixel appears in the cycle after its byte, and header and hunting bytes give no
// output. Sizes are clamped to 1..MAX_SIDE when written. Depends on cfhd_pkg, the
// interfaces, cfhd_window and cfhd_payload.
`default_nettype none

module camera_frame_header_deframer
    import cfhd_pkg::*;
#(
    parameter int MAX_SIDE = 4096
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIDE_W-1:0]    cfg_data,
    cfhd_byte_if.sink                 raw,
    cfhd_pixel_if.source              pixels
);

    localparam logic [16:0] MAX_SIDE_W = 17'(MAX_SIDE);

    logic [SIDE_W-1:0] width_reg;
    logic [SIDE_W-1:0] height_reg;
    logic [SIDE_W-1:0] cfg_clamped;

    logic              accept;
    logic              in_ready;
    logic              header_hit;
    logic              in_payload;
    cfhd_result_t      result;

    logic              out_valid_reg;
    logic [7:0]        pixel_reg;
    logic              last_reg;
    logic [31:0]       frame_number_reg;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_clamped = {{(SIDE_W-1){1'b0}}, 1'b1};
        end
        else if ({{(17-SIDE_W){1'b0}}, cfg_data} > MAX_SIDE_W)
        begin
            cfg_clamped = MAX_SIDE_W[SIDE_W-1:0];
        end
        else
        begin
            cfg_clamped = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RESET;
            height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_clamped;
                REG_FRAME_HEIGHT: height_reg <= cfg_clamped;
                default:          ;
            endcase
        end
    end

    assign in_ready  = !out_valid_reg || pixels.ready;
    assign raw.ready = in_ready;
    assign accept    = raw.valid && in_ready;

    cfhd_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (accept && !in_payload),
        .in_byte    (raw.in_byte),
        .header_hit (header_hit)
    );

    cfhd_payload u_payload (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (raw.in_byte),
        .header_hit (header_hit),
        .width      (width_reg),
        .height     (height_reg),
        .in_payload (in_payload),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pixels.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            pixel_reg        <= result.pixel;
            last_reg         <= result.frame_last;
            frame_number_reg <= result.frame_number;
        end
    end

    assign pixels.valid        = out_valid_reg;
    assign pixels.pixel        = pixel_reg;
    assign pixels.frame_last   = last_reg;
    assign pixels.frame_number = frame_number_reg;

endmodule

`default_nettype wire

// ===== sim/tb_camera_frame_header_deframer.sv =====
// Self-checking testbench for camera_frame_header_deframer: drives raw bytes and size writes,
// predicts every pixel transfer in step with the byte stream and checks the pixel stream.
// Depends on cfhd_pkg, cfhd_byte_if, cfhd_pixel_if and the deframer RTL.
`default_nettype none

module tb_camera_frame_header_deframer;
    import cfhd_pkg::*;

    localparam int MAX_SIDE      = 4096;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int STREAM_ITEMS  = 1200;

    typedef struct packed {
        logic [7:0]            pixel;
        logic                  frame_last;
        logic [FRAMECNT_W-1:0] frame_number;
    } pixel_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIDE_W-1:0]    cfg_data;

    cfhd_byte_if  raw_if();
    cfhd_pixel_if pix_if();

    camera_frame_header_deframer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .raw       (raw_if),
        .pixels    (pix_if)
    );

    // predicted deframer state
    logic [7:0]            sync_window [HEADER_BYTES];
    bit                    in_frame;
    logic [PIXCNT_W-1:0]   pixel_index;
    logic [FRAMECNT_W-1:0] frames_found;
    logic [SIDE_W-1:0]     width_reg;
    logic [SIDE_W-1:0]     height_reg;

    pixel_t pending_pixels[$];
    int     mismatches;
    int     stream_items;
    bit     no_idle;
    int     stall_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int unsigned side_of(logic [SIDE_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return v;
    endfunction

    function automatic int unsigned burst_len();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        int unsigned total;
        pixel_t      px;
        if (in_frame)
        begin
            total           = side_of(width_reg) * side_of(height_reg);
            px.pixel        = b;
            px.frame_last   = (int'(pixel_index) + 1 >= total);
            px.frame_number = frames_found;
            pending_pixels.push_back(px);
            if (px.frame_last)
            begin
                in_frame    = 1'b0;
                pixel_index = '0;
            end
            else
                pixel_index = pixel_index + 1'b1;
            return;
        end
        for (int i = 0; i < HEADER_BYTES - 1; i++)
            sync_window[i] = sync_window[i + 1];
        sync_window[HEADER_BYTES - 1] = b;
        if (sync_window[0] == SYNC_A && sync_window[1] == SYNC_B &&
            sync_window[HEADER_BYTES - 2] == SYNC_C && sync_window[HEADER_BYTES - 1] == SYNC_D)
        begin
            frames_found = frames_found + 1'b1;
            in_frame     = 1'b1;
            pixel_index  = '0;
            for (int i = 0; i < HEADER_BYTES; i++)
                sync_window[i] = 8'h00;
        end
    endfunction

    // predict on each byte transfer, then check each pixel transfer
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg = cfg_data;
                    REG_FRAME_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (raw_if.valid && raw_if.ready)
                deframe_byte(raw_if.in_byte);
            if (pix_if.valid && pix_if.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel %02h last %0b frame %0d",
                                 pix_if.pixel, pix_if.frame_last, pix_if.frame_number);
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pix_if.pixel !== want.pixel || pix_if.frame_last !== want.frame_last ||
                        pix_if.frame_number !== want.frame_number)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"pixel mismatch: expected %02h last %0b frame %0d, ",
                                      "got %02h last %0b frame %0d"},
                                     want.pixel, want.frame_last, want.frame_number,
                                     pix_if.pixel, pix_if.frame_last, pix_if.frame_number);
                    end
                end
            end
        end
    end

    // pixel sink: random stalls, none started while no_idle is set
    initial
    begin
        pix_if.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                pix_if.ready <= 1'b0;
                stall_left--;
            end
            else if (!no_idle && $urandom_range(0, 99) < 20)
            begin
                pix_if.ready <= 1'b0;
                stall_left = burst_len() - 1;
            end
            else
                pix_if.ready <= 1'b1;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_byte(logic [7:0] b);
        int unsigned gap;
        gap = idle_gap();
        repeat (gap)
        begin
            @(negedge clk);
            raw_if.valid <= 1'b0;
        end
        @(negedge clk);
        raw_if.valid   <= 1'b1;
        raw_if.in_byte <= b;
        do
            @(posedge clk);
        while (!raw_if.ready);
        stream_items++;
    endtask

    task automatic send_header(bit corrupt);
        logic [7:0]  hdr [HEADER_BYTES];
        int unsigned pos;
        for (int i = 0; i < HEADER_BYTES; i++)
            hdr[i] = 8'($urandom_range(0, 255));
        hdr[0]                = SYNC_A;
        hdr[1]                = SYNC_B;
        hdr[HEADER_BYTES - 2] = SYNC_C;
        hdr[HEADER_BYTES - 1] = SYNC_D;
        if (corrupt)
        begin
            case ($urandom_range(0, 3))
                0: pos = 0;
                1: pos = 1;
                2: pos = HEADER_BYTES - 2;
                default: pos = HEADER_BYTES - 1;
            endcase
            hdr[pos] = hdr[pos] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < HEADER_BYTES; i++)
            send_byte(hdr[i]);
    endtask

    task automatic send_payload(int unsigned count);
        repeat (count) send_byte(8'($urandom_range(0, 255)));
    endtask

    // hold the byte stream until every predicted pixel has been transferred
    task automatic wait_drained();
        @(negedge clk);
        raw_if.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sizes(logic [SIDE_W-1:0] w, logic [SIDE_W-1:0] h);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic test_hunting_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        repeat (13) send_byte(8'h5A);
        send_byte(SYNC_C);
        send_byte(SYNC_D);
    endtask

    task automatic test_smallest_frame();
        write_sizes('0, '0);
        send_header(1'b0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_header(1'b0);
        send_byte(8'h00);
    endtask

    task automatic test_back_to_back_sync();
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        repeat (10) send_byte(8'($urandom_range(0, 255)));
        send_byte(SYNC_C);
        send_byte(SYNC_D);
        send_byte(SYNC_C);
        send_byte(SYNC_D);
    endtask

    task automatic test_header_in_payload();
        write_sizes(13'd16, 13'd1);
        send_header(1'b0);
        send_header(1'b0);
        send_byte(8'hFF);
    endtask

    task automatic test_widest_frame();
        write_sizes(13'h1FFF, '0);
        send_header(1'b0);
        send_payload(40);
        write_sizes(13'd1, 13'd1);
        send_payload(1);
    endtask

    task automatic test_resize_mid_frame();
        write_sizes(13'd5, 13'd5);
        send_header(1'b0);
        send_payload(10);
        write_sizes(13'd2, 13'd2);
        send_payload(2);
        write_sizes(13'd4096, 13'h1FFF);
        send_header(1'b0);
        send_payload(20);
        write_sizes(13'd3, 13'd7);
        send_payload(2);
    endtask

    task automatic test_pause_mid_frame();
        write_sizes(13'd6, 13'd3);
        send_header(1'b0);
        send_payload(7);
        wait_drained();
        send_payload(11);
    endtask

    function automatic logic [SIDE_W-1:0] random_side(int unsigned top);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 85)
            return SIDE_W'($urandom_range(1, top));
        return SIDE_W'($urandom_range(top + 1, 3 * top));
    endfunction

    task automatic test_random_stream();
        int unsigned count;
        int unsigned kind;
        while (stream_items < STREAM_ITEMS)
        begin
            if ($urandom_range(0, 14) == 0)
                write_sizes(SIDE_W'($urandom_range(0, 63)), 13'd1);
            else
                write_sizes(random_side(8), random_side(4));
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (6)
            begin
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
                count = side_of(width_reg) * side_of(height_reg);
                kind  = $urandom_range(0, 99);
                if (kind < 75)
                begin
                    send_header(1'b0);
                    send_payload(count);
                end
                else if (kind < 85)
                begin
                    send_header(1'b0);
                    send_payload($urandom_range(0, count));
                end
                else if (kind < 93)
                    send_header(1'b1);
                else
                    repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_FRAME_WIDTH;
        cfg_data       = '0;
        raw_if.valid   = 1'b0;
        raw_if.in_byte = 8'h00;
        for (int i = 0; i < HEADER_BYTES; i++)
            sync_window[i] = 8'h00;
        in_frame     = 1'b0;
        pixel_index  = '0;
        frames_found = '0;
        width_reg    = FRAME_WIDTH_RESET;
        height_reg   = FRAME_HEIGHT_RESET;
        mismatches   = 0;
        stream_items = 0;
        no_idle      = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_hunting_noise();
        test_smallest_frame();
        test_back_to_back_sync();
        test_header_in_payload();
        test_widest_frame();
        test_resize_mid_frame();
        test_pause_mid_frame();
        test_random_stream();

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/cfhd_pkg.sv
rtl/cfhd_byte_if.sv
rtl/cfhd_pixel_if.sv
rtl/cfhd_window.sv
rtl/cfhd_payload.sv
rtl/camera_frame_header_deframer.sv
sim/tb_camera_frame_header_deframer.sv
